FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. Simulation only; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication under reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication under reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/swc_pkg.sv
// ----------------------------------------------------------------------------
// swc_pkg
// Types, codes, duty patterns and the sweep target function of the
// square-wave channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swc_pkg;

    // Event codes carried in the kind field
    localparam logic [1:0] KIND_TIMER   = 2'd0;
    localparam logic [1:0] KIND_QUARTER = 2'd1;
    localparam logic [1:0] KIND_HALF    = 2'd2;
    localparam logic [1:0] KIND_WRITE   = 2'd3;

    // Channel register indexes
    localparam logic [1:0] REG_CTRL      = 2'd0;
    localparam logic [1:0] REG_SWEEP     = 2'd1;
    localparam logic [1:0] REG_PERIOD_LO = 2'd2;
    localparam logic [1:0] REG_PERIOD_HI = 2'd3;

    // Config port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic CFG_SECOND_CHANNEL = 1'b0;  // word select paddr[2]

    localparam logic [10:0] PERIOD_MIN  = 11'd8;
    localparam logic [3:0]  DECAY_MAX   = 4'd15;

    typedef logic [1:0] kind_t;
    typedef logic [1:0] reg_idx_t;
    typedef logic [7:0] byte_t;
    typedef logic [3:0] sample_t;

    // Duty waveforms, bit k is the level at sequencer step k
    localparam logic [7:0] DUTY_PATTERN [4] = '{
        8'b0000_0010,
        8'b0000_0110,
        8'b0001_1110,
        8'b1111_1001
    };

    typedef struct packed {
        logic [10:0] target;
        logic        muted;
    } swc_sweep_t;

    // Sweep target and mute flag for a given period and sweep setup
    function automatic swc_sweep_t swc_sweep(
        input logic [10:0] period,
        input logic [2:0]  shift,
        input logic        negate,
        input logic        twos
    );
        logic [10:0] change;
        logic [11:0] sub;
        logic [11:0] sum;
        swc_sweep_t  r;
        change = period >> shift;
        sub    = {1'b0, change} + {11'd0, ~twos};
        sum    = {1'b0, period} + {1'b0, change};
        if (negate)
        begin
            r.target = (sub > {1'b0, period}) ? 11'd0 : (period - sub[10:0]);
            r.muted  = (period < PERIOD_MIN);
        end
        else
        begin
            r.target = sum[10:0];
            r.muted  = (period < PERIOD_MIN) || sum[11];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/swc_in_if.sv
// ----------------------------------------------------------------------------
// swc_in_if
// Event channel into the square-wave channel: valid/ready plus payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface swc_in_if
    import swc_pkg::*;
();
    logic     valid;
    logic     ready;
    kind_t    kind;
    reg_idx_t reg_index;
    byte_t    write_data;
    byte_t    length_load;

    modport source (output valid, kind, reg_index, write_data, length_load, input ready);
    modport sink   (input valid, kind, reg_index, write_data, length_load, output ready);
endinterface

`default_nettype wire

FILE: rtl/swc_out_if.sv
// ----------------------------------------------------------------------------
// swc_out_if
// Sample channel out of the square-wave channel: valid/ready plus sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface swc_out_if
    import swc_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t sample;

    modport source (output valid, sample, input ready);
    modport sink   (input valid, sample, output ready);
endinterface

`default_nettype wire

FILE: rtl/square_wave_channel.sv
// Path: a beat accepted passes the input register, then the result register,
// before its sample shows.
// Throughput: one beat per cycle unless the output stalls; the single update pass sets the pace.
// Output stalls back up through the result and input registers.
// Reset (rst_n low, async) clears all channel state, config and valids.
// ----------------------------------------------------------------------------
// square_wave_channel
// Square-wave sound channel: period divider, duty sequencer, envelope,
// length counter and sweep, updated once per event beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module square_wave_channel
    import swc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    swc_in_if.sink                     in_ch,
    swc_out_if.source                  out_ch,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    // Config register
    logic second_channel_reg;
    logic cfg_wr;

    // Input register
    logic     s1_valid_reg;
    kind_t    s1_kind_reg;
    reg_idx_t s1_idx_reg;
    byte_t    s1_data_reg;
    byte_t    s1_load_reg;
    logic     s1_move;

    // Output register
    logic    out_valid_reg;
    sample_t sample_reg;
    sample_t sample_next;

    // Channel state
    byte_t       chan_reg      [4];
    byte_t       chan_next     [4];
    logic [10:0] period_div_reg, period_div_next;
    logic [2:0]  duty_step_reg,  duty_step_next;
    logic [3:0]  env_div_reg,    env_div_next;
    logic [3:0]  decay_reg,      decay_next;
    logic        env_restart_reg, env_restart_next;
    logic [2:0]  sweep_div_reg,  sweep_div_next;
    logic        sweep_reload_reg, sweep_reload_next;
    byte_t       length_reg,     length_next;

    logic [10:0] period_cur;
    logic [10:0] period_new;
    swc_sweep_t  sweep_cur;
    swc_sweep_t  sweep_new;
    logic [3:0]  volume;

    // APB config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == CFG_SECOND_CHANNEL)
                  ? {{(APB_DATA_W-1){1'b0}}, second_channel_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            second_channel_reg <= 1'b0;
        else if (cfg_wr && (paddr[2] == CFG_SECOND_CHANNEL))
            second_channel_reg <= pwdata[0];
    end

    // Handshake
    assign s1_move      = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !s1_valid_reg || s1_move;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.sample = sample_reg;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ch.ready)
            s1_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_kind_reg <= in_ch.kind;
            s1_idx_reg  <= in_ch.reg_index;
            s1_data_reg <= in_ch.write_data;
            s1_load_reg <= in_ch.length_load;
        end
    end

    // Sweep on current registers
    assign period_cur = {chan_reg[REG_PERIOD_HI][2:0], chan_reg[REG_PERIOD_LO]};
    assign sweep_cur  = swc_sweep(period_cur, chan_reg[REG_SWEEP][2:0],
                                  chan_reg[REG_SWEEP][3], second_channel_reg);

    // Event update
    always_comb
    begin
        chan_next         = chan_reg;
        period_div_next   = period_div_reg;
        duty_step_next    = duty_step_reg;
        env_div_next      = env_div_reg;
        decay_next        = decay_reg;
        env_restart_next  = env_restart_reg;
        sweep_div_next    = sweep_div_reg;
        sweep_reload_next = sweep_reload_reg;
        length_next       = length_reg;

        unique case (s1_kind_reg)
            KIND_TIMER:
            begin
                if (period_div_reg == 11'd0)
                begin
                    duty_step_next  = duty_step_reg + 3'd1;
                    period_div_next = period_cur;
                end
                else
                    period_div_next = period_div_reg - 11'd1;
            end
            KIND_QUARTER:
            begin
                if (env_restart_reg)
                begin
                    env_restart_next = 1'b0;
                    decay_next       = DECAY_MAX;
                    env_div_next     = chan_reg[REG_CTRL][3:0];
                end
                else if (env_div_reg == 4'd0)
                begin
                    env_div_next = chan_reg[REG_CTRL][3:0];
                    if (decay_reg != 4'd0)
                        decay_next = decay_reg - 4'd1;
                    else if (chan_reg[REG_CTRL][5])
                        decay_next = DECAY_MAX;
                end
                else
                    env_div_next = env_div_reg - 4'd1;
            end
            KIND_HALF:
            begin
                if (length_reg != 8'd0 && !chan_reg[REG_CTRL][5])
                    length_next = length_reg - 8'd1;
                if (sweep_div_reg == 3'd0 && chan_reg[REG_SWEEP][7] &&
                    chan_reg[REG_SWEEP][2:0] != 3'd0 && !sweep_cur.muted)
                begin
                    chan_next[REG_PERIOD_LO] = sweep_cur.target[7:0];
                    chan_next[REG_PERIOD_HI] = {chan_reg[REG_PERIOD_HI][7:3],
                                                sweep_cur.target[10:8]};
                end
                if (sweep_div_reg == 3'd0 || sweep_reload_reg)
                begin
                    sweep_div_next    = chan_reg[REG_SWEEP][6:4];
                    sweep_reload_next = 1'b0;
                end
                else
                    sweep_div_next = sweep_div_reg - 3'd1;
            end
            KIND_WRITE:
            begin
                chan_next[s1_idx_reg] = s1_data_reg;
                if (s1_idx_reg == REG_SWEEP)
                    sweep_reload_next = 1'b1;
                else if (s1_idx_reg == REG_PERIOD_HI)
                begin
                    length_next      = s1_load_reg;
                    env_restart_next = 1'b1;
                    duty_step_next   = 3'd0;
                end
            end
        endcase
    end

    // Sample from the updated state
    assign period_new = {chan_next[REG_PERIOD_HI][2:0], chan_next[REG_PERIOD_LO]};
    assign sweep_new  = swc_sweep(period_new, chan_next[REG_SWEEP][2:0],
                                  chan_next[REG_SWEEP][3], second_channel_reg);
    assign volume     = chan_next[REG_CTRL][4] ? chan_next[REG_CTRL][3:0] : decay_next;

    always_comb
    begin
        if (sweep_new.muted || length_next == 8'd0)
            sample_next = 4'd0;
        else if (DUTY_PATTERN[chan_next[REG_CTRL][7:6]][duty_step_next])
            sample_next = volume;
        else
            sample_next = 4'd0;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                chan_reg[i] <= 8'd0;
            period_div_reg   <= 11'd0;
            duty_step_reg    <= 3'd0;
            env_div_reg      <= 4'd0;
            decay_reg        <= 4'd0;
            env_restart_reg  <= 1'b0;
            sweep_div_reg    <= 3'd0;
            sweep_reload_reg <= 1'b0;
            length_reg       <= 8'd0;
        end
        else if (s1_move)
        begin
            chan_reg         <= chan_next;
            period_div_reg   <= period_div_next;
            duty_step_reg    <= duty_step_next;
            env_div_reg      <= env_div_next;
            decay_reg        <= decay_next;
            env_restart_reg  <= env_restart_next;
            sweep_div_reg    <= sweep_div_next;
            sweep_reload_reg <= sweep_reload_next;
            length_reg       <= length_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_move)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
            sample_reg <= sample_next;
    end

    // Checks
    `ASSERT_IMP(a_ready_when_out_free, clk, rst_n, !out_valid_reg, in_ch.ready)
    `ASSERT_NEXT(a_state_holds_when_idle, clk, rst_n, !s1_move,
        $stable(duty_step_reg) && $stable(length_reg) && $stable(decay_reg))
    `ASSERT_NEXT(a_length_zero_sticks, clk, rst_n,
        length_reg == 8'd0 && !(s1_move && s1_kind_reg == KIND_WRITE &&
        s1_idx_reg == REG_PERIOD_HI), length_reg == 8'd0)
    `ASSERT_NEXT(a_stage_holds_on_stall, clk, rst_n, s1_valid_reg && !s1_move,
        s1_valid_reg && out_valid_reg)

endmodule

`default_nettype wire
